// ===== rtl/ihdq_pkg.sv =====
// Shared constants and codes for the interval heap priority queue.
`default_nettype none
package ihdq_pkg;
  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = IDX_W + 2;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_MIN = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_MAX = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REPLACE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/ihdq_req_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
`default_nettype none
interface ihdq_req_if;
  logic                           valid;
  logic                           ready;
  logic [ihdq_pkg::REQ_W-1:0]     req_type;
  logic [ihdq_pkg::KEY_W-1:0]     key;
  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface
`default_nettype wire

// ===== rtl/ihdq_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one result word.
`default_nettype none
interface ihdq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ihdq_pkg::KEY_W-1:0]  popped_key;
  logic [ihdq_pkg::KEY_W-1:0]  min_key;
  logic [ihdq_pkg::KEY_W-1:0]  max_key;
  logic [ihdq_pkg::CNT_W-1:0]  entry_count;
  logic                        is_empty;
  logic [ihdq_pkg::STAT_W-1:0] status;
  modport source (output valid, popped_key, min_key, max_key, entry_count, is_empty, status,
                  input ready);
  modport sink   (input valid, popped_key, min_key, max_key, entry_count, is_empty, status,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/ihdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ihdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/interval_heap_double_ended_queue.sv =====
// Interval heap double-ended priority queue: top level with heap sequencer.
// Usage:
//   in_req  (sink):   one request word per handshake: req_type and key.
//                     Codes: insert, pop minimum, pop maximum, replace maximum,
//                     clear; other codes leave the heap as it is.
//   out_rsp (source): one result word per request: popped or displaced key,
//                     minimum, maximum, count, empty flag and status.
// Requests are served one at a time; in_req.ready is high while the sequencer
// is idle, also while the previous result still waits in the output register.
// A removal sifts down through S_DN_A, S_DN_B and S_DN_C for each heap level;
// on the way up each level passes S_UP_LOOP and S_UP_MAX on the max side, and
// S_UP_MIN as well on the min side. Every comparison waits for one registered
// read from the single read port of the key memory. The next request is
// accepted in the cycle after the result loads.
// Reset empties the queue (count to zero); memory contents are not cleared,
// since only slots below the count are ever read.
// When the receiver stalls, the finished result holds in the output register
// and the next request, once accepted, completes and waits until the result
// word ahead of it is taken.
`default_nettype none
module interval_heap_double_ended_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  ihdq_req_if.sink   in_req,
  ihdq_rsp_if.source out_rsp
);
  localparam int KW = ihdq_pkg::KEY_W;
  localparam int IW = ihdq_pkg::IDX_W;
  localparam int CW = ihdq_pkg::CNT_W;
  localparam int EW = ihdq_pkg::EXT_W;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_LD_POP   = 17'h00002,
    S_LD_TEMP  = 17'h00004,
    S_POPR     = 17'h00008,
    S_DN_A     = 17'h00010,
    S_DN_B     = 17'h00020,
    S_DN_C     = 17'h00040,
    S_UP_START = 17'h00080,
    S_UP_PAIR  = 17'h00100,
    S_UP_LOOP  = 17'h00200,
    S_UP_MAX   = 17'h00400,
    S_UP_MIN   = 17'h00800,
    S_WR_FIN   = 17'h01000,
    S_FIN      = 17'h02000,
    S_FIN_R0   = 17'h04000,
    S_FIN_R1   = 17'h08000,
    S_DONE     = 17'h10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ihdq_pkg::REQ_W-1:0]    req_r, req_nxt;
  logic [KW-1:0]                 temp_r, temp_nxt;
  logic [IW-1:0]                 k_r, k_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [KW-1:0]                 popped_r, popped_nxt;
  logic [ihdq_pkg::STAT_W-1:0]   status_r, status_nxt;
  logic [KW-1:0]                 a_r, a_nxt;
  logic [KW-1:0]                 max_r, max_nxt;

  logic                          out_valid_r;
  logic [KW-1:0]                 out_popped_r, out_min_r, out_max_r;
  logic [CW-1:0]                 out_cnt_r;
  logic [ihdq_pkg::STAT_W-1:0]   out_status_r;
  logic                          out_load;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr, ram_raddr;
  logic [KW-1:0]                 ram_wdata, rd;

  logic [EW-1:0] k_ext, cnt_ext, ca, cb;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] pair, pmax, pmin;
  logic          take_a, dn_move;
  logic [KW-1:0] dn_val;
  logic [IW-1:0] dn_idx;
  logic          accept;

  ihdq_ram #(.WIDTH(KW), .DEPTH(ihdq_pkg::CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && (state_r == S_IDLE);

  // Index arithmetic for the current slot
  assign k_ext   = EW'(k_r);
  assign cnt_ext = EW'(cnt_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign ca      = k_r[0] ? ((k_ext << 1) + EW'(1)) : ((k_ext << 1) + EW'(2));
  assign cb      = ca + EW'(2);
  assign pair    = k_r ^ IW'(1);
  assign pmax    = ((k_r >> 1) - IW'(1)) & ~IW'(1);
  assign pmin    = pmax | IW'(1);

  // Pick the child on the min or max path and decide whether it moves up
  assign take_a  = k_r[0] ? (a_r < rd) : (rd < a_r);
  assign dn_val  = (state_r == S_DN_C && !take_a) ? rd : ((state_r == S_DN_C) ? a_r : rd);
  assign dn_idx  = (state_r == S_DN_C && !take_a) ? cb[IW-1:0] : ca[IW-1:0];
  assign dn_move = k_r[0] ? (dn_val < temp_r) : (temp_r < dn_val);

  // Heap sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    temp_nxt   = temp_r;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    a_nxt      = a_r;
    max_nxt    = max_r;
    ram_we     = 1'b0;
    ram_waddr  = k_r;
    ram_wdata  = temp_r;
    ram_raddr  = '0;
    out_load   = 1'b0;
    unique case (state_r) inside
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_req.req_type;
          temp_nxt   = in_req.key;
          popped_nxt = '0;
          status_nxt = ihdq_pkg::STAT_OK;
          state_nxt  = S_FIN;
          case (in_req.req_type) inside
            ihdq_pkg::REQ_INSERT: begin
              if (cnt_r >= CW'(ihdq_pkg::CAPACITY)) begin
                status_nxt = ihdq_pkg::STAT_FULL;
              end else begin
                k_nxt     = cnt_r[IW-1:0];
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_START;
              end
            end
            ihdq_pkg::REQ_POP_MIN, ihdq_pkg::REQ_POP_MAX, ihdq_pkg::REQ_REPLACE: begin
              if (cnt_r == '0) begin
                status_nxt = ihdq_pkg::STAT_EMPTY;
              end else if (in_req.req_type == ihdq_pkg::REQ_POP_MIN && cnt_r < CW'(3)) begin
                ram_raddr = cnt_m1[IW-1:0];
                cnt_nxt   = cnt_m1;
                state_nxt = S_POPR;
              end else if (in_req.req_type == ihdq_pkg::REQ_POP_MIN) begin
                ram_raddr = IW'(1);
                k_nxt     = IW'(1);
                state_nxt = S_LD_POP;
              end else if (in_req.req_type == ihdq_pkg::REQ_POP_MAX && cnt_r < CW'(2)) begin
                ram_raddr = '0;
                cnt_nxt   = '0;
                state_nxt = S_POPR;
              end else begin
                ram_raddr = '0;
                k_nxt     = '0;
                state_nxt = S_LD_POP;
              end
            end
            ihdq_pkg::REQ_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_LD_POP: begin
        popped_nxt = rd;
        if (req_r == ihdq_pkg::REQ_REPLACE) begin
          state_nxt = S_DN_A;
        end else begin
          ram_raddr = cnt_m1[IW-1:0];
          cnt_nxt   = cnt_m1;
          state_nxt = S_LD_TEMP;
        end
      end
      S_LD_TEMP: begin
        temp_nxt  = rd;
        state_nxt = S_DN_A;
      end
      S_POPR: begin
        popped_nxt = rd;
        state_nxt  = S_FIN;
      end
      S_DN_A: begin
        if (ca < cnt_ext) begin
          ram_raddr = ca[IW-1:0];
          state_nxt = S_DN_B;
        end else begin
          state_nxt = S_UP_START;
        end
      end
      S_DN_B, S_DN_C: begin
        if (state_r == S_DN_B) begin
          a_nxt = rd;
        end
        if (state_r == S_DN_B && cb < cnt_ext) begin
          ram_raddr = cb[IW-1:0];
          state_nxt = S_DN_C;
        end else if (dn_move) begin
          ram_we    = 1'b1;
          ram_wdata = dn_val;
          k_nxt     = dn_idx;
          state_nxt = S_DN_A;
        end else begin
          state_nxt = S_UP_START;
        end
      end
      S_UP_START: begin
        if (EW'(k_r | IW'(1)) < cnt_ext) begin
          ram_raddr = pair;
          state_nxt = S_UP_PAIR;
        end else begin
          state_nxt = S_UP_LOOP;
        end
      end
      S_UP_PAIR: begin
        if (k_r[0] ? (temp_r > rd) : (temp_r < rd)) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          k_nxt     = pair;
        end
        state_nxt = S_UP_LOOP;
      end
      S_UP_LOOP: begin
        if (k_r > IW'(1)) begin
          ram_raddr = pmax;
          state_nxt = S_UP_MAX;
        end else begin
          state_nxt = S_WR_FIN;
        end
      end
      S_UP_MAX: begin
        if (temp_r > rd) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          k_nxt     = pmax;
          state_nxt = S_UP_LOOP;
        end else begin
          ram_raddr = pmin;
          state_nxt = S_UP_MIN;
        end
      end
      S_UP_MIN: begin
        if (temp_r < rd) begin
          ram_we    = 1'b1;
          ram_wdata = rd;
          k_nxt     = pmin;
          state_nxt = S_UP_LOOP;
        end else begin
          state_nxt = S_WR_FIN;
        end
      end
      S_WR_FIN: begin
        ram_we    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (cnt_r == '0) begin
          max_nxt   = '0;
          a_nxt     = '0;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = '0;
          state_nxt = S_FIN_R0;
        end
      end
      S_FIN_R0: begin
        max_nxt = rd;
        if (cnt_r < CW'(2)) begin
          a_nxt     = rd;
          state_nxt = S_DONE;
        end else begin
          ram_raddr = IW'(1);
          state_nxt = S_FIN_R1;
        end
      end
      S_FIN_R1: begin
        a_nxt     = rd;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    temp_r   <= temp_nxt;
    k_r      <= k_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    a_r      <= a_nxt;
    max_r    <= max_nxt;
    if (out_load) begin
      out_popped_r <= popped_r;
      out_min_r    <= a_r;
      out_max_r    <= max_r;
      out_cnt_r    <= cnt_r;
      out_status_r <= status_r;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.popped_key  = out_popped_r;
  assign out_rsp.min_key     = out_min_r;
  assign out_rsp.max_key     = out_max_r;
  assign out_rsp.entry_count = out_cnt_r;
  assign out_rsp.is_empty    = (out_cnt_r == '0);
  assign out_rsp.status      = out_status_r;
endmodule
`default_nettype wire

// ===== rtl/ihdq_checker.sv =====
// Port-level checks on the priority queue's result words, bound to the top level.
`default_nettype none
module ihdq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ihdq_pkg::KEY_W-1:0]  popped_key,
  input wire logic [ihdq_pkg::KEY_W-1:0]  min_key,
  input wire logic [ihdq_pkg::KEY_W-1:0]  max_key,
  input wire logic [ihdq_pkg::CNT_W-1:0]  entry_count,
  input wire logic                        is_empty,
  input wire logic [ihdq_pkg::STAT_W-1:0] status
);
  // Empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  // A stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Minimum never exceeds maximum
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_empty |-> (min_key <= max_key))
    else $error("minimum above maximum");

  // Failed requests remove nothing
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ihdq_pkg::STAT_OK) |-> (popped_key == '0))
    else $error("failed request reports a key");

  // Count stays within capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (entry_count <= ihdq_pkg::CNT_W'(ihdq_pkg::CAPACITY)))
    else $error("count above capacity");
endmodule

bind interval_heap_double_ended_queue ihdq_checker u_ihdq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .popped_key  (out_rsp.popped_key),
  .min_key     (out_rsp.min_key),
  .max_key     (out_rsp.max_key),
  .entry_count (out_rsp.entry_count),
  .is_empty    (out_rsp.is_empty),
  .status      (out_rsp.status)
);
`default_nettype wire
